// ----- rtl/ist_pkg.sv -----
// Package for the identifier set table: sizes, command codes, character
// classes and the pending-name status type. No dependencies.
`default_nettype none

package ist_pkg;

  localparam int MAX_ENTRIES    = 128;
  localparam int MAX_NAME_BYTES = 128;

  // byte index within a row, name length, entry count, store address
  localparam int BW = $clog2(MAX_NAME_BYTES);
  localparam int LW = $clog2(MAX_NAME_BYTES + 1);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES * MAX_NAME_BYTES);

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam logic [7:0] CH_DIGIT_9  = 8'h39;
  localparam logic [7:0] CH_UNDERSC  = 8'h5F;

  typedef struct packed {
    logic [LW-1:0] len;
    logic          valid;
  } pend_stat_t;

  function automatic logic is_lead(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c == CH_UNDERSC);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/identifier_set_table_top.sv -----
// Identifier set table, top level: name store memory and search/append sequencer.
// Depends on ist_pkg and ist_pending.
//
// Usage: the input channel (in_valid/in_stall) carries command and character
// beats. A nonzero character under add or query is buffered and gives no
// result. A zero character ends the name: the stored names are compared byte
// by byte against it, each byte with one store read and one compare; an entry
// stops at its first mismatching byte and the search stops at a hit. A new
// name is appended with one pending-buffer read and one store write per byte,
// its terminating zero included, and then the result is posted. Clear and an
// unusable name post their result directly. Command 3 is taken and dropped.
// Each terminator or clear gives one output beat (answer, entry_count) on
// out_valid/out_stall. The result sits in an output register; while the
// receiver stalls, character beats are still taken, and a further result
// waits in the sequencer with in_stall high until the register frees.
// Reset empties the set and the pending name at once; the name store
// itself is not cleared, since only written rows are ever read.
`default_nettype none

module identifier_set_table_top
  import ist_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  input  wire logic [7:0] character,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            answer,
  output logic [7:0]      entry_count
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_READ    = 6'b000010,
    S_CMP     = 6'b000100,
    S_COPY_RD = 6'b001000,
    S_COPY_WR = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t        state;
  logic [CW-1:0] stored;
  logic [CW-1:0] entry;
  logic [AW-1:0] row_base;
  logic [BW-1:0] idx;
  logic          is_add;
  logic          res_answer;

  logic          acc;
  logic          out_free;
  logic          pend_wr;
  logic          pend_restart;
  logic [7:0]    pend_rd;
  pend_stat_t    pstat;
  logic          usable;
  logic [BW-1:0] len_b;
  logic          at_end;
  logic [7:0]    expect_byte;
  logic          byte_match;
  logic          last_entry;

  logic [7:0]    store [MAX_ENTRIES * MAX_NAME_BYTES];
  logic [AW-1:0] store_addr;
  logic          store_we;
  logic [7:0]    store_wdata;
  logic [7:0]    store_rd;

  assign in_stall = (state != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign pend_wr      = acc && (command == CMD_ADD || command == CMD_QUERY) &&
                        (character != CH_NUL);
  assign pend_restart = (state == S_DONE) && out_free;

  ist_pending u_pending (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (pend_wr),
    .wr_char (character),
    .restart (pend_restart),
    .rd_idx  (idx),
    .rd_data (pend_rd),
    .stat    (pstat)
  );

  assign usable      = (pstat.len != '0) && pstat.valid &&
                       (pstat.len < LW'(MAX_NAME_BYTES));
  assign len_b       = pstat.len[BW-1:0];
  assign at_end      = (idx == len_b);
  // stored names carry a zero after the last byte; match it at the end
  assign expect_byte = at_end ? CH_NUL : pend_rd;
  assign byte_match  = (store_rd == expect_byte);
  assign last_entry  = (entry + CW'(1) == stored);

  assign store_addr  = row_base + AW'(idx);
  assign store_we    = (state == S_COPY_WR);
  assign store_wdata = expect_byte;

  always_ff @(posedge clk) begin
    if (store_we) store[store_addr] <= store_wdata;
    store_rd <= store[store_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stored     <= '0;
      entry      <= '0;
      row_base   <= '0;
      idx        <= '0;
      is_add     <= 1'b0;
      res_answer <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            entry    <= '0;
            row_base <= '0;
            idx      <= '0;
            is_add   <= (command == CMD_ADD);
            if (command == CMD_CLEAR) begin
              stored     <= '0;
              res_answer <= 1'b1;
              state      <= S_DONE;
            end else if (command != CMD_NONE && character == CH_NUL) begin
              if (!usable) begin
                res_answer <= 1'b0;
                state      <= S_DONE;
              end else if (stored == '0) begin
                if (command == CMD_ADD) begin
                  state <= S_COPY_RD;
                end else begin
                  res_answer <= 1'b0;
                  state      <= S_DONE;
                end
              end else begin
                state <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (byte_match && at_end) begin
            res_answer <= 1'b1;
            state      <= S_DONE;
          end else if (byte_match) begin
            idx   <= idx + BW'(1);
            state <= S_READ;
          end else if (!last_entry) begin
            entry    <= entry + CW'(1);
            row_base <= row_base + AW'(MAX_NAME_BYTES);
            idx      <= '0;
            state    <= S_READ;
          end else if (is_add && stored < CW'(MAX_ENTRIES)) begin
            // row after the last one is the free slot
            row_base <= row_base + AW'(MAX_NAME_BYTES);
            idx      <= '0;
            state    <= S_COPY_RD;
          end else begin
            res_answer <= 1'b0;
            state      <= S_DONE;
          end
        end
        S_COPY_RD: begin
          state <= S_COPY_WR;
        end
        S_COPY_WR: begin
          if (at_end) begin
            stored     <= stored + CW'(1);
            res_answer <= 1'b1;
            state      <= S_DONE;
          end else begin
            idx   <= idx + BW'(1);
            state <= S_COPY_RD;
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_restart) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_restart) begin
      answer      <= res_answer;
      entry_count <= 8'(stored);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ist_pending.sv -----
// Pending-name buffer: byte memory, saturating length and validity check.
// Depends on ist_pkg.
`default_nettype none

module ist_pending
  import ist_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [7:0]    wr_char,
  input  wire logic          restart,
  input  wire logic [BW-1:0] rd_idx,
  output logic [7:0]         rd_data,
  output pend_stat_t         stat
);

  logic [7:0]    mem [MAX_NAME_BYTES];
  logic [LW-1:0] len;
  logic          valid;
  logic          room;
  logic          char_ok;

  assign room    = len < LW'(MAX_NAME_BYTES);
  assign char_ok = (len == '0) ? is_lead(wr_char) : (is_lead(wr_char) || is_digit(wr_char));

  always_ff @(posedge clk) begin
    if (rst) begin
      len   <= '0;
      valid <= 1'b1;
    end else if (restart) begin
      len   <= '0;
      valid <= 1'b1;
    end else if (wr_en) begin
      if (!char_ok) valid <= 1'b0;
      if (room) len <= len + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && room) mem[len[BW-1:0]] <= wr_char;
    rd_data <= mem[rd_idx];
  end

  assign stat.len   = len;
  assign stat.valid = valid;

endmodule

`default_nettype wire
